// File: src/plbt_pkg.sv
package plbt_pkg;

    localparam int POS_W   = 64;
    localparam int CNT_W   = 32;
    localparam int CMD_W   = 4;
    localparam int IDX_W   = 2;
    localparam int STEP_W  = 7;   // holds POS_W itself

    // run state codes
    localparam logic [1:0] MODE_STOPPED = 2'd0;
    localparam logic [1:0] MODE_PLAYING = 2'd1;
    localparam logic [1:0] MODE_PAUSED  = 2'd2;
    localparam logic [1:0] MODE_RECORD  = 2'd3;

    // command codes
    localparam logic [CMD_W-1:0] CMD_PLAY     = 4'd0;
    localparam logic [CMD_W-1:0] CMD_PAUSE    = 4'd1;
    localparam logic [CMD_W-1:0] CMD_STOP     = 4'd2;
    localparam logic [CMD_W-1:0] CMD_RECORD   = 4'd3;
    localparam logic [CMD_W-1:0] CMD_STOP_REC = 4'd4;
    localparam logic [CMD_W-1:0] CMD_TOGGLE   = 4'd5;
    localparam logic [CMD_W-1:0] CMD_ADVANCE  = 4'd6;
    localparam logic [CMD_W-1:0] CMD_SET_POS  = 4'd7;
    localparam logic [CMD_W-1:0] CMD_MOVE_POS = 4'd8;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_LOOP_ENABLE = 2'd0;
    localparam logic [IDX_W-1:0] REG_LOOP_START  = 2'd1;
    localparam logic [IDX_W-1:0] REG_LOOP_END    = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MLOAD,
        ST_MRUN,
        ST_WRAP,
        ST_DONE
    } plbt_state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic mod_load;
        logic mod_step;
        logic wrap_commit;
        logic out_load;
    } plbt_ctl_t;

    // datapath to controller
    typedef struct packed {
        logic wrap_need;
        logic mod_done;
    } plbt_sts_t;

endpackage

// File: src/plbt_rem.sv
module plbt_rem (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    load,
    input  logic                    step,
    input  logic [plbt_pkg::POS_W-1:0] dividend,
    input  logic [plbt_pkg::POS_W-1:0] divisor,
    output logic [plbt_pkg::POS_W-1:0] remainder,
    output logic                    done
);
    import plbt_pkg::*;

    logic [POS_W-1:0]  rem_reg, rem_next;
    logic [POS_W-1:0]  dvd_reg, dvd_next;
    logic [POS_W-1:0]  dvs_reg;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [POS_W:0]    trial;
    logic [POS_W:0]    diff;

    // restoring remainder, one dividend bit per step
    always_comb begin
        trial    = {rem_reg, dvd_reg[POS_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        rem_next = rem_reg;
        dvd_next = dvd_reg;
        cnt_next = cnt_reg;
        if (load) begin
            rem_next = '0;
            dvd_next = dividend;
            cnt_next = '0;
        end else if (step) begin
            rem_next = diff[POS_W] ? trial[POS_W-1:0] : diff[POS_W-1:0];
            dvd_next = {dvd_reg[POS_W-2:0], 1'b0};
            cnt_next = cnt_reg + STEP_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= STEP_W'(POS_W);
        end else begin
            cnt_reg <= cnt_next;
        end
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        if (load) begin
            dvs_reg <= divisor;
        end
    end

    assign remainder = rem_reg;
    assign done      = (cnt_reg == STEP_W'(POS_W));

endmodule

// File: src/plbt_dp.sv
module plbt_dp (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  plbt_pkg::plbt_ctl_t         ctl,
    output plbt_pkg::plbt_sts_t         sts,
    input  logic [plbt_pkg::CMD_W-1:0]  s_cmd,
    input  logic                        s_reset_to_zero,
    input  logic [plbt_pkg::CNT_W-1:0]  s_sample_count,
    input  logic [plbt_pkg::POS_W-1:0]  s_target_position,
    input  logic signed [plbt_pkg::POS_W-1:0] s_position_delta,
    input  logic                        cfg_we,
    input  logic [plbt_pkg::IDX_W-1:0]  cfg_index,
    input  logic [plbt_pkg::POS_W-1:0]  cfg_data,
    output logic [1:0]                  m_run_state,
    output logic                        m_armed,
    output logic [plbt_pkg::POS_W-1:0]  m_sample_position,
    output logic                        m_loop_wrapped,
    output logic                        m_state_event,
    output logic                        m_position_event
);
    import plbt_pkg::*;

    // configuration
    logic             loop_en_reg;
    logic [POS_W-1:0] loop_start_reg;
    logic [POS_W-1:0] loop_end_reg;

    // transport state
    logic [1:0]       mode_reg, mode_next;
    logic             armed_reg, armed_next;
    logic [POS_W-1:0] pos_reg, pos_next;

    // captured request
    logic [CMD_W-1:0] cmd_reg;
    logic             rz_reg;
    logic [CNT_W-1:0] count_reg;
    logic [POS_W-1:0] target_reg;
    logic [POS_W-1:0] delta_reg;

    // per-request results
    logic             evs_reg, evs_next;
    logic             evp_reg, evp_next;
    logic             wrapped_reg, wrapped_next;
    logic [POS_W-1:0] np_reg;

    // output register
    logic [1:0]       out_mode_reg;
    logic             out_armed_reg;
    logic [POS_W-1:0] out_pos_reg;
    logic             out_wrap_reg;
    logic             out_evs_reg;
    logic             out_evp_reg;

    logic             active;
    logic             go_pause;
    logic [POS_W-1:0] adv_pos;
    logic             wrap_hit;
    logic [POS_W+1:0] move_sum;
    logic [POS_W-1:0] rem;
    logic             rem_done;

    assign active   = (mode_reg == MODE_PLAYING) || (mode_reg == MODE_RECORD);
    assign go_pause = (cmd_reg == CMD_PAUSE) || ((cmd_reg == CMD_TOGGLE) && active);
    assign adv_pos  = pos_reg + {{(POS_W-CNT_W){1'b0}}, count_reg};
    assign wrap_hit = loop_en_reg && (loop_end_reg > loop_start_reg) && (adv_pos >= loop_end_reg);
    assign move_sum = {2'b00, pos_reg} + {{2{delta_reg[POS_W-1]}}, delta_reg};

    always_comb begin
        mode_next    = mode_reg;
        armed_next   = armed_reg;
        pos_next     = pos_reg;
        evs_next     = 1'b0;
        evp_next     = 1'b0;
        wrapped_next = 1'b0;
        unique case (cmd_reg)
            CMD_PLAY, CMD_PAUSE, CMD_TOGGLE: begin
                if (go_pause) begin
                    if (mode_reg != MODE_STOPPED && mode_reg != MODE_PAUSED) begin
                        if (mode_reg == MODE_RECORD) begin
                            armed_next = 1'b0;
                        end
                        mode_next = MODE_PAUSED;
                        evs_next  = 1'b1;
                    end
                end else if (mode_reg != MODE_RECORD) begin
                    mode_next = armed_reg ? MODE_RECORD : MODE_PLAYING;
                    evs_next  = 1'b1;
                end
            end
            CMD_STOP: begin
                if (mode_reg != MODE_STOPPED || rz_reg) begin
                    armed_next = 1'b0;
                    mode_next  = MODE_STOPPED;
                    evs_next   = 1'b1;
                    if (rz_reg) begin
                        pos_next = '0;
                        evp_next = 1'b1;
                    end
                end
            end
            CMD_RECORD: begin
                armed_next = 1'b1;
                mode_next  = MODE_RECORD;
                evs_next   = 1'b1;
            end
            CMD_STOP_REC: begin
                armed_next = 1'b0;
                if (mode_reg == MODE_RECORD) begin
                    mode_next = MODE_PLAYING;
                    evs_next  = 1'b1;
                end
            end
            CMD_ADVANCE: begin
                if (active) begin
                    if (wrap_hit) begin
                        // position lands after the remainder pass
                        wrapped_next = 1'b1;
                    end else begin
                        pos_next = adv_pos;
                    end
                end
            end
            CMD_SET_POS: begin
                pos_next = target_reg;
                evp_next = 1'b1;
            end
            CMD_MOVE_POS: begin
                // clamp below zero, saturate above the top
                if (move_sum[POS_W+1]) begin
                    pos_next = '0;
                end else if (move_sum[POS_W]) begin
                    pos_next = '1;
                end else begin
                    pos_next = move_sum[POS_W-1:0];
                end
                evp_next = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign sts.wrap_need = wrapped_next;
    assign sts.mod_done  = rem_done;

    plbt_rem u_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (ctl.mod_load),
        .step      (ctl.mod_step),
        .dividend  (np_reg - loop_end_reg),
        .divisor   (loop_end_reg - loop_start_reg),
        .remainder (rem),
        .done      (rem_done)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loop_en_reg    <= 1'b0;
            loop_start_reg <= '0;
            loop_end_reg   <= '0;
            mode_reg       <= MODE_STOPPED;
            armed_reg      <= 1'b0;
            pos_reg        <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_LOOP_ENABLE: loop_en_reg    <= cfg_data[0];
                    REG_LOOP_START:  loop_start_reg <= cfg_data;
                    REG_LOOP_END:    loop_end_reg   <= cfg_data;
                    default: begin
                    end
                endcase
            end
            if (ctl.exec) begin
                mode_reg  <= mode_next;
                armed_reg <= armed_next;
                pos_reg   <= pos_next;
            end else if (ctl.wrap_commit) begin
                pos_reg <= loop_start_reg + rem;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.capture) begin
            cmd_reg    <= s_cmd;
            rz_reg     <= s_reset_to_zero;
            count_reg  <= s_sample_count;
            target_reg <= s_target_position;
            delta_reg  <= s_position_delta;
        end
        if (ctl.exec) begin
            evs_reg     <= evs_next;
            evp_reg     <= evp_next;
            wrapped_reg <= wrapped_next;
            np_reg      <= adv_pos;
        end
        if (ctl.out_load) begin
            out_mode_reg  <= mode_reg;
            out_armed_reg <= armed_reg;
            out_pos_reg   <= pos_reg;
            out_wrap_reg  <= wrapped_reg;
            out_evs_reg   <= evs_reg;
            out_evp_reg   <= evp_reg;
        end
    end

    assign m_run_state       = out_mode_reg;
    assign m_armed           = out_armed_reg;
    assign m_sample_position = out_pos_reg;
    assign m_loop_wrapped    = out_wrap_reg;
    assign m_state_event     = out_evs_reg;
    assign m_position_event  = out_evp_reg;

endmodule

// File: src/plbt_ctrl.sv
module plbt_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  plbt_pkg::plbt_sts_t  sts,
    output plbt_pkg::plbt_ctl_t  ctl
);
    import plbt_pkg::*;

    plbt_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;
    logic        out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_valid)       state_next = ST_EXEC;
            ST_EXEC:  state_next = sts.wrap_need ? ST_MLOAD : ST_DONE;
            ST_MLOAD: state_next = ST_MRUN;
            ST_MRUN:  if (sts.mod_done)  state_next = ST_WRAP;
            ST_WRAP:  state_next = ST_DONE;
            ST_DONE:  if (out_free)      state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready         = (state_reg == ST_IDLE);
        ctl.capture     = (state_reg == ST_IDLE) && s_valid;
        ctl.exec        = (state_reg == ST_EXEC);
        ctl.mod_load    = (state_reg == ST_MLOAD);
        ctl.mod_step    = (state_reg == ST_MRUN) && !sts.mod_done;
        ctl.wrap_commit = (state_reg == ST_WRAP);
        ctl.out_load    = (state_reg == ST_DONE) && out_free;
        m_valid_next    = ctl.out_load || (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// File: src/playback_transport_loop.sv
// playback transport with loop wrap: keeps the run state (stopped, playing,
// paused, recording), a record-armed flag and a 64-bit sample position, and
// answers every command request with exactly one result request carrying the
// state after the command plus wrap and event flags. a request passes through
// the execute state to the hand-off state, which loads the result register;
// an advance that crosses the loop end first goes through the bit-serial
// remainder unit that folds the overshoot into the loop length one bit per
// cycle (64 steps). one request is in flight at a time, but the result
// register lets a new request in while the previous result waits on m_ready.
// the loop registers are written through the cfg channel, which is always
// ready; write them only while no request is in flight.
module playback_transport_loop (
    input  logic                        aclk,
    input  logic                        aresetn,

    // command requests
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [plbt_pkg::CMD_W-1:0]  s_cmd,
    input  logic                        s_reset_to_zero,
    input  logic [plbt_pkg::CNT_W-1:0]  s_sample_count,
    input  logic [plbt_pkg::POS_W-1:0]  s_target_position,
    input  logic signed [plbt_pkg::POS_W-1:0] s_position_delta,

    // result requests
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_run_state,
    output logic                        m_armed,
    output logic [plbt_pkg::POS_W-1:0]  m_sample_position,
    output logic                        m_loop_wrapped,
    output logic                        m_state_event,
    output logic                        m_position_event,

    // register writes: 0 loop_enable, 1 loop_start, 2 loop_end
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [plbt_pkg::IDX_W-1:0]  cfg_index,
    input  logic [plbt_pkg::POS_W-1:0]  cfg_data
);
    import plbt_pkg::*;

    plbt_ctl_t ctl;
    plbt_sts_t sts;

    // register writes never stall
    assign cfg_ready = 1'b1;

    // sequencer: idle, execute, optional remainder pass, result hand-off
    plbt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .ctl     (ctl)
    );

    // transport state, loop registers, remainder unit and result register
    plbt_dp u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .ctl               (ctl),
        .sts               (sts),
        .s_cmd             (s_cmd),
        .s_reset_to_zero   (s_reset_to_zero),
        .s_sample_count    (s_sample_count),
        .s_target_position (s_target_position),
        .s_position_delta  (s_position_delta),
        .cfg_we            (cfg_valid),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .m_run_state       (m_run_state),
        .m_armed           (m_armed),
        .m_sample_position (m_sample_position),
        .m_loop_wrapped    (m_loop_wrapped),
        .m_state_event     (m_state_event),
        .m_position_event  (m_position_event)
    );

endmodule
